@@ design/c3cwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package c3cwm_pkg;

    localparam int MAX_HEIGHT = 64;
    localparam int PIXEL_BITS = 16;
    localparam int ACC_W      = 32;
    localparam int ROW_W      = 6;
    localparam int DIM_W      = 7;
    localparam int TAP_W      = 4;
    localparam int NUM_TAPS   = 9;
    localparam int ADDR_W     = $clog2(MAX_HEIGHT);

    typedef logic signed [PIXEL_BITS-1:0] pixel_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic [ROW_W-1:0]             row_t;
    typedef logic [DIM_W-1:0]             dim_t;
    typedef logic [TAP_W-1:0]             tap_t;
    typedef logic [ADDR_W-1:0]            addr_t;

    typedef enum logic
    {
        REQ_WEIGHT = 1'b0,
        REQ_PIXEL  = 1'b1
    } req_t;

    typedef enum logic
    {
        CFG_HEIGHT = 1'b0,
        CFG_WIDTH  = 1'b1
    } cfg_idx_t;

    localparam dim_t DIM_RESET  = dim_t'(58);
    localparam dim_t DIM_MIN    = dim_t'(3);
    localparam dim_t HEIGHT_MAX = dim_t'(MAX_HEIGHT);
    localparam dim_t WIDTH_MAX  = dim_t'(64);
    localparam dim_t DIM_ONE    = dim_t'(1);
    localparam row_t ROW_ONE    = row_t'(1);
    localparam row_t ROW_TWO    = row_t'(2);
    localparam tap_t TAP_COUNT  = tap_t'(NUM_TAPS);

    // one column store row: the two previous columns' pixels
    typedef struct packed
    {
        pixel_t older;
        pixel_t newer;
    } pair_t;

    typedef struct packed
    {
        pixel_t [NUM_TAPS-1:0] window;
        acc_t                  acc;
        row_t                  row;
        row_t                  col;
    } mac_req_t;

endpackage

`default_nettype wire

@@ design/c3cwm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface c3cwm_in_if;
    logic              valid;
    logic              ready;
    c3cwm_pkg::req_t   req_type;
    c3cwm_pkg::tap_t   tap_index;
    c3cwm_pkg::pixel_t sample;
    c3cwm_pkg::acc_t   acc_in;

    modport source
    (
        output valid,
        output req_type,
        output tap_index,
        output sample,
        output acc_in,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  req_type,
        input  tap_index,
        input  sample,
        input  acc_in,
        output ready
    );
endinterface

interface c3cwm_out_if;
    logic            valid;
    logic            ready;
    c3cwm_pkg::row_t out_row;
    c3cwm_pkg::row_t out_col;
    c3cwm_pkg::acc_t out_value;

    modport source
    (
        output valid,
        output out_row,
        output out_col,
        output out_value,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  out_row,
        input  out_col,
        input  out_value,
        output ready
    );
endinterface

`default_nettype wire

@@ design/conv3x3_column_window_mac_top.sv @@
// Result path: item stage, then MAC product, partial-sum and sum registers.
// Throughput: one item per cycle unless the output stalls. The column store is one
// single-port-write RAM; a column's last two row updates are held in a two-entry queue
// and written in the next free write slots, and reads are forwarded from pending writes.
// Reset: position counters, taps and the two pixels above are cleared, both plane
// dimensions return to 58; the column store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module conv3x3_column_window_mac_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire c3cwm_pkg::cfg_idx_t               cfg_index,
    input  wire logic [c3cwm_pkg::DIM_W-1:0]       cfg_data,
    c3cwm_in_if.sink                               in_ch,
    c3cwm_out_if.source                            out_ch
);

    c3cwm_pkg::dim_t   height_reg;
    c3cwm_pkg::dim_t   width_reg;
    c3cwm_pkg::dim_t   hlim;
    c3cwm_pkg::dim_t   wlim;
    c3cwm_pkg::row_t   row_count_reg;
    c3cwm_pkg::row_t   row_count_next;
    c3cwm_pkg::row_t   col_count_reg;
    c3cwm_pkg::row_t   col_count_next;
    c3cwm_pkg::dim_t   row_plus1;
    c3cwm_pkg::dim_t   col_plus1;
    logic              col_end;
    logic              in_acc;

    logic              s1_valid_reg;
    c3cwm_pkg::req_t   s1_req_reg;
    c3cwm_pkg::tap_t   s1_tap_reg;
    c3cwm_pkg::pixel_t s1_sample_reg;
    c3cwm_pkg::acc_t   s1_acc_reg;
    c3cwm_pkg::row_t   s1_row_reg;
    c3cwm_pkg::row_t   s1_col_reg;
    logic              s1_end_reg;
    c3cwm_pkg::addr_t  s1_addr;
    c3cwm_pkg::row_t   s1_row_m1;
    c3cwm_pkg::row_t   s1_row_m2;
    logic              s1_is_pix;
    logic              produce;
    logic              adv1;
    logic              mac_ready;
    c3cwm_pkg::mac_req_t mac_req;

    logic              fwd_valid_reg;
    c3cwm_pkg::pair_t  fwd_data_reg;
    c3cwm_pkg::pair_t  cur_pair;
    c3cwm_pkg::pair_t  hist1_reg;
    c3cwm_pkg::pair_t  hist2_reg;
    c3cwm_pkg::pixel_t p1_reg;
    c3cwm_pkg::pixel_t p2_reg;
    c3cwm_pkg::pixel_t [c3cwm_pkg::NUM_TAPS-1:0] taps_reg;

    logic [1:0]        q_valid_reg;
    c3cwm_pkg::addr_t  q_addr_reg [2];
    c3cwm_pkg::pair_t  q_data_reg [2];
    logic              q_push;
    logic              drain;
    logic              s1_wr;
    logic              wr_en;
    c3cwm_pkg::addr_t  wr_addr;
    c3cwm_pkg::pair_t  wr_data;
    logic [$bits(c3cwm_pkg::pair_t)-1:0] ram_rd_data;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= c3cwm_pkg::DIM_RESET;
            width_reg  <= c3cwm_pkg::DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                c3cwm_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                c3cwm_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        priority if (height_reg < c3cwm_pkg::DIM_MIN)
            hlim = c3cwm_pkg::DIM_MIN;
        else if (height_reg > c3cwm_pkg::HEIGHT_MAX)
            hlim = c3cwm_pkg::HEIGHT_MAX;
        else
            hlim = height_reg;

        priority if (width_reg < c3cwm_pkg::DIM_MIN)
            wlim = c3cwm_pkg::DIM_MIN;
        else if (width_reg > c3cwm_pkg::WIDTH_MAX)
            wlim = c3cwm_pkg::WIDTH_MAX;
        else
            wlim = width_reg;
    end

    // position counters, advanced at acceptance
    assign in_acc    = in_ch.valid && in_ch.ready;
    assign row_plus1 = c3cwm_pkg::dim_t'(row_count_reg) + c3cwm_pkg::DIM_ONE;
    assign col_plus1 = c3cwm_pkg::dim_t'(col_count_reg) + c3cwm_pkg::DIM_ONE;
    assign col_end   = row_plus1 >= hlim;

    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        if (in_acc)
        begin
            priority if (in_ch.req_type == c3cwm_pkg::REQ_WEIGHT)
            begin
                row_count_next = '0;
                col_count_next = '0;
            end
            else if (col_end)
            begin
                row_count_next = '0;
                col_count_next = (col_plus1 >= wlim) ? '0
                               : col_plus1[c3cwm_pkg::ROW_W-1:0];
            end
            else
            begin
                row_count_next = row_plus1[c3cwm_pkg::ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
        end
        else
        begin
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
        end
    end

    // item stage
    assign s1_addr   = s1_row_reg[c3cwm_pkg::ADDR_W-1:0];
    assign s1_row_m1 = s1_row_reg - c3cwm_pkg::ROW_ONE;
    assign s1_row_m2 = s1_row_reg - c3cwm_pkg::ROW_TWO;
    assign s1_is_pix = s1_req_reg == c3cwm_pkg::REQ_PIXEL;
    assign produce   = s1_valid_reg && s1_is_pix
                    && (s1_row_reg >= c3cwm_pkg::ROW_TWO)
                    && (s1_col_reg >= c3cwm_pkg::ROW_TWO);
    assign adv1      = s1_valid_reg && (!produce || mac_ready);
    assign in_ch.ready = !s1_valid_reg || adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv1)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_req_reg    <= in_ch.req_type;
            s1_tap_reg    <= in_ch.tap_index;
            s1_sample_reg <= in_ch.sample;
            s1_acc_reg    <= in_ch.acc_in;
            s1_row_reg    <= row_count_reg;
            s1_col_reg    <= col_count_reg;
            s1_end_reg    <= col_end;
        end
    end

    // newest contents of the current row: queue, then late writes, then RAM
    always_comb
    begin
        cur_pair = c3cwm_pkg::pair_t'(ram_rd_data);
        if (fwd_valid_reg)
        begin
            cur_pair = fwd_data_reg;
        end
        if (q_valid_reg[1] && (q_addr_reg[1] == s1_addr))
        begin
            cur_pair = q_data_reg[1];
        end
        if (q_valid_reg[0] && (q_addr_reg[0] == s1_addr))
        begin
            cur_pair = q_data_reg[0];
        end
    end

    // column store writes: row two up now, the column's last two rows deferred
    assign s1_wr  = adv1 && s1_is_pix && (s1_row_reg >= c3cwm_pkg::ROW_TWO);
    assign q_push = adv1 && s1_is_pix && s1_end_reg;
    assign drain  = q_valid_reg[0] && !s1_wr;
    assign wr_en  = s1_wr || drain;

    always_comb
    begin
        if (s1_wr)
        begin
            wr_addr       = s1_row_m2[c3cwm_pkg::ADDR_W-1:0];
            wr_data.older = hist2_reg.newer;
            wr_data.newer = p2_reg;
        end
        else
        begin
            wr_addr = q_addr_reg[0];
            wr_data = q_data_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 2'b00;
        end
        else if (q_push)
        begin
            q_valid_reg <= 2'b11;
        end
        else if (drain)
        begin
            q_valid_reg <= {1'b0, q_valid_reg[1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_addr_reg[0]       <= s1_row_m1[c3cwm_pkg::ADDR_W-1:0];
            q_data_reg[0].older <= hist1_reg.newer;
            q_data_reg[0].newer <= p1_reg;
            q_addr_reg[1]       <= s1_addr;
            q_data_reg[1].older <= cur_pair.newer;
            q_data_reg[1].newer <= s1_sample_reg;
        end
        else if (drain)
        begin
            q_addr_reg[0] <= q_addr_reg[1];
            q_data_reg[0] <= q_data_reg[1];
        end
    end

    // writes that land after the RAM read was issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            fwd_valid_reg <= wr_en && (wr_addr == row_count_reg[c3cwm_pkg::ADDR_W-1:0]);
        end
        else if (s1_valid_reg && wr_en && (wr_addr == s1_addr))
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // window history, pixels above and taps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg   <= '0;
            p2_reg   <= '0;
            taps_reg <= '0;
        end
        else if (adv1)
        begin
            if (s1_is_pix)
            begin
                p2_reg <= p1_reg;
                p1_reg <= s1_sample_reg;
            end
            else if (s1_tap_reg < c3cwm_pkg::TAP_COUNT)
            begin
                taps_reg[s1_tap_reg] <= s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && s1_is_pix)
        begin
            hist2_reg <= hist1_reg;
            hist1_reg <= cur_pair;
        end
    end

    c3cwm_ram #(
        .WIDTH ($bits(c3cwm_pkg::pair_t)),
        .DEPTH (c3cwm_pkg::MAX_HEIGHT)
    ) u_column_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (in_acc),
        .rd_addr (row_count_reg[c3cwm_pkg::ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        mac_req.window[0] = hist2_reg.older;
        mac_req.window[1] = hist2_reg.newer;
        mac_req.window[2] = p2_reg;
        mac_req.window[3] = hist1_reg.older;
        mac_req.window[4] = hist1_reg.newer;
        mac_req.window[5] = p1_reg;
        mac_req.window[6] = cur_pair.older;
        mac_req.window[7] = cur_pair.newer;
        mac_req.window[8] = s1_sample_reg;
        mac_req.acc       = s1_acc_reg;
        mac_req.row       = s1_row_m2;
        mac_req.col       = s1_col_reg - c3cwm_pkg::ROW_TWO;
    end

    c3cwm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (produce),
        .req_ready (mac_ready),
        .req       (mac_req),
        .taps      (taps_reg),
        .out_ch    (out_ch)
    );

    a_queue_empty_on_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_valid_reg == 2'b00))
        else $error("column end while deferred row writes still pending");

    a_queue_drained_before_window_write: assert property (@(posedge clk) disable iff (!rst_n)
        s1_wr |-> !q_valid_reg[0])
        else $error("deferred row write still pending at a row update");

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.req_type == c3cwm_pkg::REQ_PIXEL))
        |=> ((row_count_reg == '0)
            || (row_count_reg == ($past(row_count_reg) + c3cwm_pkg::ROW_ONE))))
        else $error("row counter skipped a row");

endmodule

`default_nettype wire

@@ design/c3cwm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module c3cwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/c3cwm_mac.sv @@
`timescale 1ns / 1ps
`default_nettype none

module c3cwm_mac (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          req_valid,
    output logic                                               req_ready,
    input  wire c3cwm_pkg::mac_req_t                           req,
    input  wire c3cwm_pkg::pixel_t [c3cwm_pkg::NUM_TAPS-1:0]   taps,
    c3cwm_out_if.source                                        out_ch
);

    logic            v2_reg;
    logic            v3_reg;
    logic            v4_reg;
    logic            rdy2;
    logic            rdy3;
    logic            rdy4;
    c3cwm_pkg::acc_t prod_next [c3cwm_pkg::NUM_TAPS];
    c3cwm_pkg::acc_t prod_reg  [c3cwm_pkg::NUM_TAPS];
    c3cwm_pkg::acc_t acc2_reg;
    c3cwm_pkg::row_t row2_reg;
    c3cwm_pkg::row_t col2_reg;
    c3cwm_pkg::acc_t part_next [3];
    c3cwm_pkg::acc_t part_reg  [3];
    c3cwm_pkg::row_t row3_reg;
    c3cwm_pkg::row_t col3_reg;
    c3cwm_pkg::acc_t value_next;
    c3cwm_pkg::acc_t value_reg;
    c3cwm_pkg::row_t row4_reg;
    c3cwm_pkg::row_t col4_reg;

    assign rdy4      = !v4_reg || out_ch.ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign req_ready = rdy2;

    always_comb
    begin
        for (int k = 0; k < c3cwm_pkg::NUM_TAPS; k++)
        begin
            prod_next[k] = c3cwm_pkg::acc_t'(signed'(taps[k]))
                         * c3cwm_pkg::acc_t'(signed'(req.window[k]));
        end
    end

    always_comb
    begin
        part_next[0] = acc2_reg + prod_reg[0] + prod_reg[1] + prod_reg[2];
        part_next[1] = prod_reg[3] + prod_reg[4] + prod_reg[5];
        part_next[2] = prod_reg[6] + prod_reg[7] + prod_reg[8];
        value_next   = part_reg[0] + part_reg[1] + part_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
            begin
                v2_reg <= req_valid;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && req_valid)
        begin
            prod_reg <= prod_next;
            acc2_reg <= req.acc;
            row2_reg <= req.row;
            col2_reg <= req.col;
        end
        if (rdy3 && v2_reg)
        begin
            part_reg <= part_next;
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            value_reg <= value_next;
            row4_reg  <= row3_reg;
            col4_reg  <= col3_reg;
        end
    end

    assign out_ch.valid     = v4_reg;
    assign out_ch.out_row   = row4_reg;
    assign out_ch.out_col   = col4_reg;
    assign out_ch.out_value = value_reg;

endmodule

`default_nettype wire

@@ verif/conv3x3_column_window_mac_top_tb.sv @@
`timescale 1ns / 1ps

module conv3x3_column_window_mac_top_tb;

    import c3cwm_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_PRINTED    = 20;

    typedef struct packed
    {
        row_t row;
        row_t col;
        acc_t value;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    dim_t cfg_data;

    c3cwm_in_if  in_ch ();
    c3cwm_out_if out_ch ();

    conv3x3_column_window_mac_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    pixel_t      kernel [NUM_TAPS];
    pixel_t      col_old [MAX_HEIGHT];
    pixel_t      col_new [MAX_HEIGHT];
    pixel_t      up_one;
    pixel_t      up_two;
    int unsigned row_pos;
    int unsigned col_pos;
    dim_t        height_reg;
    dim_t        width_reg;

    window_result_t window_q [$];

    int unsigned send_idle_pct  = 14;
    int unsigned recv_stall_pct = 50;
    int unsigned items_sent;
    int unsigned weights_sent;
    int unsigned reg_writes;
    int unsigned windows_checked;
    int unsigned error_count;
    int unsigned quiet_cycles;

    function automatic void shift_column_row(int unsigned r, pixel_t px);
        int unsigned idx;
        idx = r % MAX_HEIGHT;
        col_old[idx] = col_new[idx];
        col_new[idx] = px;
    endfunction

    function automatic void predict_window(req_t kind, tap_t tap, pixel_t px, acc_t acc);
        int unsigned h;
        int unsigned w;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        acc_t        sum;
        pixel_t      win [NUM_TAPS];
        h = (height_reg < DIM_MIN) ? DIM_MIN :
            ((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);
        w = (width_reg < DIM_MIN) ? DIM_MIN :
            ((width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg);
        r = row_pos;
        c = col_pos;
        if (kind == REQ_WEIGHT)
        begin
            if (tap < TAP_COUNT)
                kernel[tap] = px;
            row_pos = 0;
            col_pos = 0;
            return;
        end
        if (r >= 2 && c >= 2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                idx = (r - 2 + k) % MAX_HEIGHT;
                win[k * 3]     = col_old[idx];
                win[k * 3 + 1] = col_new[idx];
            end
            win[2] = up_two;
            win[5] = up_one;
            win[8] = px;
            sum = acc;
            for (int k = 0; k < NUM_TAPS; k++)
                sum += acc_t'(kernel[k]) * acc_t'(win[k]);
            window_q.push_back('{row: row_t'(r - 2), col: row_t'(c - 2), value: sum});
        end
        if (r >= 2)
            shift_column_row(r - 2, up_two);
        if (r + 1 >= h)
        begin
            if (r >= 1)
                shift_column_row(r - 1, up_one);
            shift_column_row(r, px);
            row_pos = 0;
            col_pos = (c + 1 >= w) ? 0 : c + 1;
        end
        else
            row_pos = r + 1;
        up_two = up_one;
        up_one = px;
    endfunction

    function automatic pixel_t pick_sample();
        int unsigned roll = $urandom_range(0, 15);
        if (roll == 0)
            return 16'sh8000;
        else if (roll == 1)
            return 16'sh7fff;
        else if (roll == 2)
            return '0;
        return pixel_t'($urandom);
    endfunction

    function automatic dim_t pick_dim();
        int unsigned roll = $urandom_range(0, 19);
        if (roll < 13)
            return dim_t'($urandom_range(3, 10));
        else if (roll < 15)
            return WIDTH_MAX;
        else if (roll < 17)
            return dim_t'($urandom_range(0, 2));
        else if (roll < 18)
            return dim_t'($urandom_range(65, 127));
        return dim_t'($urandom_range(11, 40));
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_item(input req_t kind, input tap_t tap, input pixel_t px, input acc_t acc);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid     <= 1'b1;
        in_ch.req_type  <= kind;
        in_ch.tap_index <= tap;
        in_ch.sample    <= px;
        in_ch.acc_in    <= acc;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        predict_window(kind, tap, px, acc);
        items_sent++;
        if (kind == REQ_WEIGHT)
            weights_sent++;
    endtask

    task automatic push_pixel(input pixel_t px, input acc_t acc);
        push_item(REQ_PIXEL, tap_t'($urandom), px, acc);
    endtask

    // stop sending, let every result out, then let trailing no-result items clear
    task automatic drain_pipeline();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (window_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_plane_reg(input cfg_idx_t which, input dim_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (which == CFG_HEIGHT)
            height_reg = value;
        else
            width_reg = value;
        reg_writes++;
    endtask

    // two full 64-row columns so no window ever reads an unwritten store entry
    task automatic test_prime_column_store();
        write_plane_reg(CFG_HEIGHT, HEIGHT_MAX);
        write_plane_reg(CFG_WIDTH, WIDTH_MAX);
        repeat (2 * MAX_HEIGHT) push_pixel(pick_sample(), acc_t'($urandom));
    endtask

    task automatic test_kernel_extremes();
        pixel_t taps_in [NUM_TAPS] = '{16'sh8000, 16'sh7fff, 16'sd1, -16'sd1, 16'sd2,
                                      -16'sd2, 16'sd12345, -16'sd23456, 16'sd3};
        pixel_t plane_in [9] = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
        drain_pipeline();
        write_plane_reg(CFG_HEIGHT, DIM_MIN);
        write_plane_reg(CFG_WIDTH, DIM_MIN);
        for (int k = 0; k < NUM_TAPS; k++)
            push_item(REQ_WEIGHT, tap_t'(k), taps_in[k], acc_t'($urandom));
        push_item(REQ_WEIGHT, TAP_COUNT, 16'sd999, '0);
        push_item(REQ_WEIGHT, '1, -16'sd1, '0);
        for (int k = 0; k < 8; k++)
            push_pixel(plane_in[k], acc_t'($urandom));
        push_pixel(plane_in[8], 32'sh7fffffff);
    endtask

    // saturated register values, and limits moved below the counters mid-plane
    task automatic test_register_edges();
        drain_pipeline();
        write_plane_reg(CFG_HEIGHT, '0);
        write_plane_reg(CFG_WIDTH, '1);
        for (int k = 0; k < 12; k++)
            push_pixel(k[0] ? 16'sh8000 : 16'sh7fff, 32'sh80000000);
        drain_pipeline();
        write_plane_reg(CFG_HEIGHT, '1);
        repeat (4) push_pixel(pick_sample(), acc_t'($urandom));
        drain_pipeline();
        write_plane_reg(CFG_HEIGHT, dim_t'(2));
        repeat (4) push_pixel(pick_sample(), acc_t'($urandom));
        drain_pipeline();
        write_plane_reg(CFG_WIDTH, dim_t'(2));
        repeat (4) push_pixel(pick_sample(), acc_t'($urandom));
        push_item(REQ_WEIGHT, tap_t'(12), 16'sd77, '0);
        repeat (4) push_pixel(pick_sample(), acc_t'($urandom));
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                       input int unsigned count);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int seg = 0; seg < 4; seg++)
        begin
            drain_pipeline();
            write_plane_reg(CFG_HEIGHT, pick_dim());
            write_plane_reg(CFG_WIDTH, pick_dim());
            for (int n = 0; n < count / 4; n++)
            begin
                if ($urandom_range(0, 99) < 3)
                    push_item(REQ_WEIGHT, tap_t'($urandom_range(0, 15)), pick_sample(),
                              acc_t'($urandom));
                else
                    push_pixel(pick_sample(), acc_t'($urandom));
            end
        end
    endtask

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : check_windows
        window_result_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (window_q.size() == 0)
                report_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                          out_ch.out_row, out_ch.out_col, out_ch.out_value));
            else
            begin
                want = window_q.pop_front();
                windows_checked++;
                if (out_ch.out_row !== want.row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              out_ch.out_row, want.row));
                if (out_ch.out_col !== want.col)
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              out_ch.out_col, want.col));
                if (out_ch.out_value !== want.value)
                    report_mismatch($sformatf("out_value %0d, expected %0d at row %0d col %0d",
                                              out_ch.out_value, want.value, want.row, want.col));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, window_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_HEIGHT;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_WEIGHT;
        in_ch.tap_index = '0;
        in_ch.sample    = '0;
        in_ch.acc_in    = '0;
        out_ch.ready    = 1'b0;
        quiet_cycles    = 0;
        items_sent      = 0;
        weights_sent    = 0;
        reg_writes      = 0;
        windows_checked = 0;
        error_count     = 0;
        for (int k = 0; k < NUM_TAPS; k++)
            kernel[k] = '0;
        for (int k = 0; k < MAX_HEIGHT; k++)
        begin
            col_old[k] = '0;
            col_new[k] = '0;
        end
        up_one     = '0;
        up_two     = '0;
        row_pos    = 0;
        col_pos    = 0;
        height_reg = DIM_RESET;
        width_reg  = DIM_RESET;

        repeat (11) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        test_prime_column_store();
        test_kernel_extremes();
        test_register_edges();
        test_random_traffic(14, 50, 420);
        test_random_traffic(50, 14, 420);
        test_random_traffic(0, 0, 420);
        drain_pipeline();

        $display("Run covered %0d input items (%0d weight loads) over %0d register writes",
                 items_sent, weights_sent, reg_writes);
        $display("%0d window results checked, %0d mismatches", windows_checked, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
design/c3cwm_pkg.sv
design/c3cwm_if.sv
design/c3cwm_ram.sv
design/c3cwm_mac.sv
design/conv3x3_column_window_mac_top.sv
verif/conv3x3_column_window_mac_top_tb.sv
